// File: design/snpid_pkg.sv
package snpid_pkg;

   // Fixed-point formats
   localparam int DATA_W    = 32;                // Q16.16 data
   localparam int FRAC_BITS = 16;
   localparam int WFRAC     = 24;                // Q8.24 weights
   localparam int RATE_W    = 16;
   localparam int DBAND_W   = 31;

   // Working widths
   localparam int XW     = DATA_W + 2;           // error differences
   localparam int SABS_W = DATA_W + 2;           // sum of weight magnitudes
   localparam int QW     = WFRAC + 1;            // normalised weight magnitude
   localparam int WNW    = WFRAC + 2;            // signed normalised weight
   localparam int REM_W  = SABS_W + 2;
   localparam int SUM_W  = 40;
   localparam int MA_W   = 64;
   localparam int DIG_W  = 16;
   localparam int NDIG   = 3;
   localparam int MB_W   = DIG_W * NDIG;
   localparam int PROD_W = MA_W + MB_W;

   localparam int NTERM = 3;
   localparam int TERM_W = 2;

   localparam int REQ_DATA_W = 2 * DATA_W;
   localparam int CSR_ADDR_W = 3;

   localparam logic signed [DATA_W-1:0] W_INIT  = DATA_W'(1677722);
   localparam logic [MA_W-1:0]          MAG_CAP = MA_W'(1) << 62;

   typedef enum logic [1:0] {
      SH_WGT  = 2'd0,   // normalised weight product
      SH_DATA = 2'd1,   // data-unit product and gain
      SH_RATE = 2'd2    // learning rate into Q8.24
   } shift_type;

   typedef struct packed {
      logic                   start;
      logic signed [MA_W-1:0] a;
      logic signed [MB_W-1:0] b;
      shift_type              sh;
   } mul_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [MA_W-1:0] res;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] num;
      logic [SABS_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [QW-1:0] quo;
   } div_rsp_type;

endpackage

// File: design/snpid_div.sv
module snpid_div (
   input  logic                     clock,
   input  logic                     reset,
   input  snpid_pkg::div_req_type   div_req,
   output snpid_pkg::div_rsp_type   div_rsp
);
   import snpid_pkg::*;

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type        state_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [SABS_W-1:0] den_ff;
   logic [QW-1:0]     quo_ff;
   logic [4:0]        cnt_ff;
   logic              done_ff;

   logic              ge;
   logic [REM_W-1:0]  rem_sub;

   // restoring step: one quotient bit a cycle
   always_comb begin
      ge      = rem_ff >= REM_W'(den_ff);
      rem_sub = ge ? rem_ff - REM_W'(den_ff) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (div_req.start) begin
                  rem_ff   <= REM_W'(div_req.num);
                  den_ff   <= div_req.den;
                  cnt_ff   <= 5'(QW - 1);
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= rem_sub << 1;
               quo_ff <= {quo_ff[QW-2:0], ge};
               if (cnt_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

// File: design/snpid_mul.sv
module snpid_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  snpid_pkg::mul_req_type   mul_req,
   output snpid_pkg::mul_rsp_type   mul_rsp
);
   import snpid_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_RUN, M_OUT} mstate_type;

   mstate_type              state_ff;
   logic [MA_W-1:0]         ma_ff;
   logic [MB_W-1:0]         mb_ff;
   logic                    neg_ff;
   shift_type               sh_ff;
   logic [PROD_W-1:0]       acc_ff;
   logic [1:0]              dig_ff;
   logic                    done_ff;
   logic signed [MA_W-1:0]  res_ff;

   logic [DIG_W-1:0]        digit;
   logic [MA_W+DIG_W-1:0]   pp;
   logic [PROD_W-1:0]       shifted;
   logic [MA_W-1:0]         mag;
   logic [MA_W-1:0]         a_mag;
   logic [MB_W-1:0]         b_mag;

   always_comb begin
      a_mag = mul_req.a[MA_W-1] ? MA_W'(-mul_req.a) : MA_W'(mul_req.a);
      b_mag = mul_req.b[MB_W-1] ? MB_W'(-mul_req.b) : MB_W'(mul_req.b);
      digit = mb_ff[dig_ff*DIG_W +: DIG_W];
      pp    = (MA_W+DIG_W)'(ma_ff) * (MA_W+DIG_W)'(digit);
      unique case (sh_ff)
         SH_WGT:  shifted = acc_ff >> WFRAC;
         SH_DATA: shifted = acc_ff >> FRAC_BITS;
         SH_RATE: shifted = acc_ff >> (FRAC_BITS + RATE_W - WFRAC);
         default: shifted = acc_ff;
      endcase
      // magnitude capped at 2^62
      mag = (shifted > PROD_W'(MAG_CAP)) ? MAG_CAP : shifted[MA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (mul_req.start) begin
                  ma_ff    <= a_mag;
                  mb_ff    <= b_mag;
                  neg_ff   <= mul_req.a[MA_W-1] ^ mul_req.b[MB_W-1];
                  sh_ff    <= mul_req.sh;
                  acc_ff   <= '0;
                  dig_ff   <= 2'(NDIG - 1);
                  state_ff <= M_RUN;
               end
            end
            M_RUN: begin
               // top digit first
               acc_ff <= (acc_ff << DIG_W) + PROD_W'(pp);
               if (dig_ff == '0) state_ff <= M_OUT;
               else dig_ff <= dig_ff - 2'd1;
            end
            M_OUT: begin
               res_ff   <= neg_ff ? -$signed(mag) : $signed(mag);
               done_ff  <= 1'b1;
               state_ff <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.res  = res_ff;

endmodule

// File: design/single_neuron_adaptive_pid.sv
// Single-neuron adaptive incremental PID controller.
// req channel: one word per sample. tuser is the kind (0 control step,
// 1 restart), tdata carries target and feedback, both signed Q16.16.
// rsp channel: exactly one word per req word, in order: the clamped drive
// and two flags (output limited, error inside the deadband).
// csr port: write-only registers, taken on any edge with csr_wr_en high;
// write only while no word is in flight.
// A restart resets the controller state and goes straight to the output
// step; a step inside the deadband skips the divisions, the multiplies and
// the weight update. A full step uses the shared units: three divisions
// (weight normalisation, one quotient bit a cycle) and eleven multiplies on
// one 64x16 multiplier, three 16-bit digits each. One word is worked on at
// a time; req_tready is high only when the sequencer is idle.
// The rsp word sits in an output register, so a new req word is taken
// while it waits. If the receiver stalls, the next result waits in the
// last sequencer step until the register frees.
// Reset (synchronous, active high) loads the default registers and the
// initial state: output 0, error history 0, all three weights 0.10.
module single_neuron_adaptive_pid (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [snpid_pkg::REQ_DATA_W-1:0]  req_tdata,  // target, feedback
   input  logic                              req_tuser,  // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [snpid_pkg::DATA_W-1:0]      rsp_tdata,  // drive
   output logic [1:0]                        rsp_tuser,  // clamped, in_band
   input  logic                              csr_wr_en,
   input  logic [snpid_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [snpid_pkg::DATA_W-1:0]      csr_wdata
);
   import snpid_pkg::*;

   typedef enum logic [2:0] {
      CSR_GAIN   = 3'd0,
      CSR_RPROP  = 3'd1,
      CSR_RINTEG = 3'd2,
      CSR_RDERIV = 3'd3,
      CSR_OMIN   = 3'd4,
      CSR_OMAX   = 3'd5,
      CSR_DBAND  = 3'd6
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_DIV, ST_DOT, ST_GAIN, ST_CLAMP,
      ST_EU, ST_TMUL, ST_DWMUL, ST_FIN
   } state_type;

   localparam logic signed [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};

   // registers
   logic [RATE_W-1:0]         gain_ff, rprop_ff, rinteg_ff, rderiv_ff;
   logic signed [DATA_W-1:0]  omin_ff, omax_ff;
   logic [DBAND_W-1:0]        dband_ff;

   // controller state
   logic signed [DATA_W-1:0]  acc_ff, el_ff, ep_ff, wi_ff, wp_ff, wd_ff;

   // sequencer and working values
   state_type                 state_ff;
   logic                      launched_ff;
   logic [TERM_W-1:0]         idx_ff;
   logic                      kind_ff;
   logic signed [DATA_W-1:0]  tgt_ff, fb_ff, err_ff;
   logic signed [XW-1:0]      xs_ff [NTERM];
   logic signed [WNW-1:0]     wn_ff [NTERM];
   logic                      band_ff, clamp_ff;
   logic [SABS_W-1:0]         sabs_ff;
   logic signed [SUM_W-1:0]   sum_ff, delta_ff;
   logic signed [MA_W-1:0]    eu_ff, t_ff;

   logic                      rsp_valid_ff;
   logic [DATA_W-1:0]         rsp_data_ff;
   logic [1:0]                rsp_user_ff;

   mul_req_type               mul_req;
   mul_rsp_type               mul_rsp;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   logic signed [DATA_W:0]    diff;
   logic signed [DATA_W-1:0]  e_c, w_sel;
   logic [DATA_W-1:0]         e_mag, w_mag;
   logic signed [XW-1:0]      x0_c, x1_c, x2_c, x_sel;
   logic [SABS_W-1:0]         sabs_c;
   logic [RATE_W-1:0]         rate_sel;
   logic signed [SUM_W:0]     r_c, r1_c, omax_x, omin_x;
   logic                      hi_c, lo_c;
   logic signed [MA_W-1:0]    wsum;
   logic signed [DATA_W-1:0]  wnew;

   function automatic logic [DATA_W-1:0] abs_d(input logic signed [DATA_W-1:0] v);
      abs_d = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
   endfunction

   always_comb begin
      // error, saturated to data width
      diff  = $signed({tgt_ff[DATA_W-1], tgt_ff}) - $signed({fb_ff[DATA_W-1], fb_ff});
      if (diff[DATA_W] != diff[DATA_W-1]) e_c = diff[DATA_W] ? DMIN : DMAX;
      else e_c = diff[DATA_W-1:0];
      e_mag = abs_d(e_c);
      x0_c  = XW'(e_c);
      x1_c  = XW'(e_c) - XW'(el_ff);
      x2_c  = XW'(e_c) - (XW'(el_ff) <<< 1) + XW'(ep_ff);
      sabs_c = SABS_W'(abs_d(wi_ff)) + SABS_W'(abs_d(wp_ff)) + SABS_W'(abs_d(wd_ff));

      // term select: integ with x0, prop with x1, deriv with x2
      unique case (idx_ff)
         2'd0:    begin w_sel = wi_ff; rate_sel = rinteg_ff; end
         2'd1:    begin w_sel = wp_ff; rate_sel = rprop_ff;  end
         default: begin w_sel = wd_ff; rate_sel = rderiv_ff; end
      endcase
      w_mag = abs_d(w_sel);
      x_sel = xs_ff[idx_ff];

      // output update and clamp, upper limit first
      r_c    = (SUM_W+1)'(acc_ff) + (SUM_W+1)'(delta_ff);
      omax_x = (SUM_W+1)'(omax_ff);
      omin_x = (SUM_W+1)'(omin_ff);
      hi_c   = r_c > omax_x;
      r1_c   = hi_c ? omax_x : r_c;
      lo_c   = r1_c < omin_x;

      // weight update with 32-bit saturation
      wsum = MA_W'(w_sel) + mul_rsp.res;
      if (wsum > MA_W'(DMAX))      wnew = DMAX;
      else if (wsum < MA_W'(DMIN)) wnew = DMIN;
      else                         wnew = wsum[DATA_W-1:0];

      // shared unit requests
      mul_req.start = !launched_ff && (state_ff == ST_DOT || state_ff == ST_GAIN ||
                       state_ff == ST_EU || state_ff == ST_TMUL || state_ff == ST_DWMUL);
      unique case (state_ff)
         ST_DOT: begin
            mul_req.a  = MA_W'(x_sel);
            mul_req.b  = MB_W'(wn_ff[idx_ff]);
            mul_req.sh = SH_WGT;
         end
         ST_GAIN: begin
            mul_req.a  = MA_W'(sum_ff);
            mul_req.b  = MB_W'({1'b0, gain_ff});
            mul_req.sh = SH_DATA;
         end
         ST_EU: begin
            mul_req.a  = MA_W'(err_ff);
            mul_req.b  = MB_W'(acc_ff);
            mul_req.sh = SH_DATA;
         end
         ST_TMUL: begin
            mul_req.a  = eu_ff;
            mul_req.b  = MB_W'(x_sel);
            mul_req.sh = SH_DATA;
         end
         default: begin
            mul_req.a  = t_ff;
            mul_req.b  = MB_W'({1'b0, rate_sel});
            mul_req.sh = SH_RATE;
         end
      endcase
      div_req.start = !launched_ff && state_ff == ST_DIV;
      div_req.num   = w_mag;
      div_req.den   = sabs_ff;
   end

   snpid_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   snpid_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= RATE_W'(7864);
         rprop_ff  <= RATE_W'(29491);
         rinteg_ff <= RATE_W'(3277);
         rderiv_ff <= '0;
         omin_ff   <= '0;
         omax_ff   <= DATA_W'(6553600);
         dband_ff  <= DBAND_W'(3277);
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_GAIN:   gain_ff   <= csr_wdata[RATE_W-1:0];
            CSR_RPROP:  rprop_ff  <= csr_wdata[RATE_W-1:0];
            CSR_RINTEG: rinteg_ff <= csr_wdata[RATE_W-1:0];
            CSR_RDERIV: rderiv_ff <= csr_wdata[RATE_W-1:0];
            CSR_OMIN:   omin_ff   <= csr_wdata;
            CSR_OMAX:   omax_ff   <= csr_wdata;
            CSR_DBAND:  dband_ff  <= csr_wdata[DBAND_W-1:0];
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser;
         tgt_ff  <= req_tdata[DATA_W-1:0];
         fb_ff   <= req_tdata[REQ_DATA_W-1:DATA_W];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         el_ff        <= '0;
         ep_ff        <= '0;
         wi_ff        <= W_INIT;
         wp_ff        <= W_INIT;
         wd_ff        <= W_INIT;
      end else begin
         // the last step reloads the output register itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FIN) rsp_valid_ff <= 1'b0;
         if (mul_req.start || div_req.start) launched_ff <= 1'b1;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_PREP;
            end
            ST_PREP: begin
               idx_ff <= '0;
               if (kind_ff) begin
                  acc_ff   <= omin_ff;
                  el_ff    <= '0;
                  ep_ff    <= '0;
                  wi_ff    <= W_INIT;
                  wp_ff    <= W_INIT;
                  wd_ff    <= W_INIT;
                  clamp_ff <= 1'b0;
                  band_ff  <= 1'b0;
                  state_ff <= ST_FIN;
               end else begin
                  err_ff   <= e_c;
                  xs_ff[0] <= x0_c;
                  xs_ff[1] <= x1_c;
                  xs_ff[2] <= x2_c;
                  band_ff  <= e_mag <= DATA_W'(dband_ff);
                  sabs_ff  <= sabs_c;
                  sum_ff   <= '0;
                  delta_ff <= '0;
                  if (e_mag <= DATA_W'(dband_ff) || sabs_c == '0) state_ff <= ST_CLAMP;
                  else state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  launched_ff    <= 1'b0;
                  wn_ff[idx_ff]  <= w_sel[DATA_W-1] ? -$signed(WNW'(div_rsp.quo))
                                                    :  $signed(WNW'(div_rsp.quo));
                  if (idx_ff == TERM_W'(NTERM - 1)) begin
                     idx_ff   <= '0;
                     state_ff <= ST_DOT;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_DOT: begin
               if (mul_rsp.done) begin
                  launched_ff <= 1'b0;
                  sum_ff      <= sum_ff + mul_rsp.res[SUM_W-1:0];
                  if (idx_ff == TERM_W'(NTERM - 1)) begin
                     idx_ff   <= '0;
                     state_ff <= ST_GAIN;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_GAIN: begin
               if (mul_rsp.done) begin
                  launched_ff <= 1'b0;
                  delta_ff    <= mul_rsp.res[SUM_W-1:0];
                  state_ff    <= ST_CLAMP;
               end
            end
            ST_CLAMP: begin
               acc_ff   <= lo_c ? omin_ff : r1_c[DATA_W-1:0];
               clamp_ff <= hi_c || lo_c;
               ep_ff    <= el_ff;
               el_ff    <= err_ff;
               state_ff <= band_ff ? ST_FIN : ST_EU;
            end
            ST_EU: begin
               if (mul_rsp.done) begin
                  launched_ff <= 1'b0;
                  eu_ff       <= mul_rsp.res;
                  state_ff    <= ST_TMUL;
               end
            end
            ST_TMUL: begin
               if (mul_rsp.done) begin
                  launched_ff <= 1'b0;
                  t_ff        <= mul_rsp.res;
                  state_ff    <= ST_DWMUL;
               end
            end
            ST_DWMUL: begin
               if (mul_rsp.done) begin
                  launched_ff <= 1'b0;
                  unique case (idx_ff)
                     2'd0:    wi_ff <= wnew;
                     2'd1:    wp_ff <= wnew;
                     default: wd_ff <= wnew;
                  endcase
                  if (idx_ff == TERM_W'(NTERM - 1)) begin
                     state_ff <= ST_FIN;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_TMUL;
                  end
               end
            end
            ST_FIN: begin
               // wait for the output register to free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= acc_ff;
                  rsp_user_ff  <= {band_ff, clamp_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: design/snpid_checker.sv
module snpid_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [snpid_pkg::DATA_W-1:0]      rsp_tdata
);
   import snpid_pkg::*;

   // after reset: idle and nothing to send
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("not idle after reset");

   // one word at a time: busy straight after taking a word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("took a second word while busy");

   // a new result only ever leaves the sequencer's busy phase
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result dropped");

endmodule

bind single_neuron_adaptive_pid snpid_checker u_snpid_checker (.*);
